// ----- hdl/lss_pkg.sv -----
// Package for the LIFO stack with search: item structs, operation codes
// and status codes. No dependencies; used by every module of the block.
package lss_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned FIELD_W = 7;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] status_t;

  localparam mode_t MODE_PUSH   = 2'd0;
  localparam mode_t MODE_POP    = 2'd1;
  localparam mode_t MODE_SEARCH = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    mode_t                     mode;
    logic signed [WORD_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  popped_value;
    logic [FIELD_W-1:0]        position;
    status_t                   status;
    logic [FIELD_W-1:0]        entry_count;
  } out_t;

endpackage

// ----- hdl/lss_mem.sv -----
// Stack storage: DEPTH words, one write port and one read port with
// registered read data. Depends on lss_pkg for the word width.
module lss_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [lss_pkg::WORD_W-1:0]  wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [lss_pkg::WORD_W-1:0]  rdata
);

  logic [lss_pkg::WORD_W-1:0] mem_r [DEPTH];
  logic [lss_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/lss_ctrl.sv -----
// Sequencer of the stack: holds the entry count, drives the storage ports
// and walks the store with one shared comparator during a search.
// Depends on lss_pkg and drives an lss_mem instance through the top level.
module lss_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned CW    = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lss_pkg::in_t                in_item,
  output logic                        res_valid,
  input  logic                        res_ready,
  output lss_pkg::out_t               res_item,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [lss_pkg::WORD_W-1:0]  mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  logic [lss_pkg::WORD_W-1:0]  mem_rdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_POPRD = 4'b0010,
    S_SRCH  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                depth_r, depth_nxt;
  logic [CW-1:0]                k_r, k_nxt;
  logic [AW-1:0]                addr_r, addr_nxt;
  logic [lss_pkg::WORD_W-1:0]   key_r, key_nxt;
  logic [lss_pkg::WORD_W-1:0]   popped_r, popped_nxt;
  logic [CW-1:0]                pos_r, pos_nxt;
  lss_pkg::status_t             status_r, status_nxt;

  logic                         start;
  logic [CW-1:0]                depth_dec;
  logic [CW-1:0]                k_inc;
  logic [AW-1:0]                top_addr;
  logic                         is_full;
  logic                         is_empty;
  logic [CW+lss_pkg::FIELD_W-1:0] pos_ext;
  logic [CW+lss_pkg::FIELD_W-1:0] cnt_ext;

  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_DONE) && res_ready);
  assign start     = in_valid && in_ready;
  assign res_valid = (state_r == S_DONE);

  assign depth_dec = depth_r - CW'(1);
  assign k_inc     = k_r + CW'(1);
  assign top_addr  = depth_dec[AW-1:0];
  assign is_full   = (depth_r == CW'(DEPTH));
  assign is_empty  = (depth_r == '0);

  // Position and count are reported modulo the width of their fields.
  assign pos_ext = {{lss_pkg::FIELD_W{1'b0}}, pos_r};
  assign cnt_ext = {{lss_pkg::FIELD_W{1'b0}}, depth_r};

  always_comb begin
    res_item.popped_value = popped_r;
    res_item.position     = pos_ext[lss_pkg::FIELD_W-1:0];
    res_item.status       = status_r;
    res_item.entry_count  = cnt_ext[lss_pkg::FIELD_W-1:0];
  end

  always_comb begin
    state_nxt  = state_r;
    depth_nxt  = depth_r;
    k_nxt      = k_r;
    addr_nxt   = addr_r;
    key_nxt    = key_r;
    popped_nxt = popped_r;
    pos_nxt    = pos_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = depth_r[AW-1:0];
    mem_wdata  = in_item.value;
    mem_re     = 1'b0;
    mem_raddr  = addr_r;

    case (state_r)
      S_IDLE: begin
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_POPRD: begin
        popped_nxt = mem_rdata;
        state_nxt  = S_DONE;
      end
      S_SRCH: begin
        // The read data holds the entry at position k_r + 1 from the top.
        if (mem_rdata == key_r) begin
          pos_nxt    = k_inc;
          status_nxt = lss_pkg::ST_OK;
          state_nxt  = S_DONE;
        end else if (k_inc == depth_r) begin
          status_nxt = lss_pkg::ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          k_nxt    = k_inc;
          mem_re   = 1'b1;
          addr_nxt = addr_r - AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (start) begin
      popped_nxt = '0;
      pos_nxt    = '0;
      status_nxt = lss_pkg::ST_OK;
      state_nxt  = S_DONE;
      case (in_item.mode)
        lss_pkg::MODE_PUSH: begin
          if (is_full) begin
            status_nxt = lss_pkg::ST_FULL;
          end else begin
            mem_we    = 1'b1;
            depth_nxt = depth_r + CW'(1);
          end
        end
        lss_pkg::MODE_POP: begin
          if (is_empty) begin
            status_nxt = lss_pkg::ST_EMPTY;
          end else begin
            depth_nxt = depth_dec;
            mem_re    = 1'b1;
            mem_raddr = top_addr;
            state_nxt = S_POPRD;
          end
        end
        lss_pkg::MODE_SEARCH: begin
          if (is_empty) begin
            status_nxt = lss_pkg::ST_EMPTY;
          end else begin
            key_nxt   = in_item.value;
            k_nxt     = '0;
            mem_re    = 1'b1;
            mem_raddr = top_addr;
            addr_nxt  = top_addr - AW'(1);
            state_nxt = S_SRCH;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      depth_r <= '0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    addr_r   <= addr_nxt;
    key_r    <= key_nxt;
    popped_r <= popped_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
  end

  a_depth_bound : assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CW'(DEPTH))
    else $error("entry count exceeds stack depth");

  a_walk_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (k_r < depth_r))
    else $error("search walk passed the bottom of the stack");

  a_push_count : assert property (@(posedge clk) disable iff (!rst_n)
    (start && (in_item.mode == lss_pkg::MODE_PUSH) && !is_full)
      |=> (depth_r == $past(depth_r) + CW'(1)))
    else $error("push did not raise the entry count");

  a_busy_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SRCH) || (state_r == S_POPRD)) |-> !in_ready)
    else $error("input taken while an item is in progress");

  a_done_follows_pop : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POPRD) |=> (state_r == S_DONE))
    else $error("pop read did not complete in one cycle");

endmodule

// ----- hdl/lifo_stack_with_search.sv -----
// Top level of the LIFO stack with search: sequencer, storage and the
// output register. Depends on lss_pkg, lss_mem and lss_ctrl.
//
//   channel  ports                          direction
//   input    in_valid, in_ready, in_item    item in: mode and value
//   result   out_valid, out_ready, out_item popped value, position, status, count
//
// A push or an unused mode goes straight to its result, a pop first reads
// the top word, and a search compares at most DEPTH entries from the top:
// the walk reads one stored word per cycle into a single comparator.
// Reset (rst_n low, synchronous) empties the stack; the storage itself is
// not cleared. A finished result waits in the output register while the
// next item is taken; a result that cannot be handed over holds the block.
module lifo_stack_with_search #(
  parameter int unsigned DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lss_pkg::in_t   in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output lss_pkg::out_t  out_item
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                        res_valid;
  logic                        res_ready;
  lss_pkg::out_t               res_item;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [lss_pkg::WORD_W-1:0]  mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [lss_pkg::WORD_W-1:0]  mem_rdata;

  logic                        out_valid_r, out_valid_nxt;
  lss_pkg::out_t               out_item_r, out_item_nxt;

  lss_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  lss_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The output register takes a new result when it is empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_item_nxt = res_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- sim/tb_lifo_stack_with_search.sv -----
// Testbench for lifo_stack_with_search: a directed opening and random push,
// pop and search traffic checked against a behavioral stack model.
// Depends on lss_pkg and the lifo_stack_with_search RTL.
`timescale 1ns / 1ps

module tb_lifo_stack_with_search;

  localparam int unsigned WORD_W = lss_pkg::WORD_W;
  localparam int unsigned FIELD_W = lss_pkg::FIELD_W;
  localparam int unsigned STACK_DEPTH = 64;
  localparam lss_pkg::mode_t MODE_IGNORED = 2'd3;
  localparam int unsigned RANDOM_OPS = 1650;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_GAP = 4;
  localparam int unsigned PRINT_CAP = 40;

  typedef struct {
    lss_pkg::in_t op;
    int unsigned  gap;
  } pending_op_t;

  logic          clk;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  lss_pkg::in_t  in_item = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  lss_pkg::out_t out_item;

  lifo_stack_with_search #(
    .DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Operations waiting to be driven, and replies the stack owes us.
  pending_op_t   pending_ops[$];
  lss_pkg::out_t stack_replies[$];

  // Behavioral copy of the stack.
  logic signed [WORD_W-1:0] model_words [STACK_DEPTH];
  int unsigned              model_count = 0;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tally_ok = 0, tally_empty = 0, tally_full = 0, tally_missing = 0;
  int unsigned deepest_match = 0;
  int unsigned ignored_ops = 0;

  function automatic lss_pkg::out_t stack_apply(lss_pkg::in_t op);
    lss_pkg::out_t r;
    int unsigned   k;
    r = '0;
    r.status = lss_pkg::ST_OK;
    case (op.mode)
      lss_pkg::MODE_PUSH: begin
        if (model_count >= STACK_DEPTH) begin
          r.status = lss_pkg::ST_FULL;
        end else begin
          model_words[model_count] = op.value;
          model_count++;
        end
      end
      lss_pkg::MODE_POP: begin
        if (model_count == 0) begin
          r.status = lss_pkg::ST_EMPTY;
        end else begin
          model_count--;
          r.popped_value = model_words[model_count];
        end
      end
      lss_pkg::MODE_SEARCH: begin
        if (model_count == 0) begin
          r.status = lss_pkg::ST_EMPTY;
        end else begin
          r.status = lss_pkg::ST_NOT_FOUND;
          // Walk from the top; the first equal word wins.
          for (k = 0; k < model_count && r.status == lss_pkg::ST_NOT_FOUND; k++) begin
            if (model_words[model_count - 1 - k] == op.value) begin
              r.position = FIELD_W'(k + 1);
              r.status = lss_pkg::ST_OK;
            end
          end
        end
      end
      default: ;
    endcase
    r.entry_count = FIELD_W'(model_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    if (error_count < PRINT_CAP)
      $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_field(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Driver: one item on the input channel at a time, with its drawn gap after it.
  int unsigned hold_off = 0;
  pending_op_t next_op;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      hold_off = 0;
    end else if (!in_valid || in_ready) begin
      if (hold_off > 0) begin
        hold_off--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        next_op = pending_ops.pop_front();
        in_item <= next_op.op;
        in_valid <= 1'b1;
        hold_off = next_op.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stalls: a fresh stall per item, with stall-free windows.
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready)
        stall_left = ((cycle_count % 1024) < 200) ? 0 : $urandom_range(0, MAX_GAP);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on every accepted input item, check every accepted result.
  lss_pkg::out_t want_reply;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (in_item.mode == MODE_IGNORED) ignored_ops++;
        stack_replies.push_back(stack_apply(in_item));
      end
      if (out_valid && out_ready) begin
        if (stack_replies.size() == 0) begin
          report_mismatch("unexpected result", out_item.popped_value, '0);
        end else begin
          want_reply = stack_replies.pop_front();
          check_field("popped_value", out_item.popped_value, want_reply.popped_value);
          check_field("position", WORD_W'(out_item.position), WORD_W'(want_reply.position));
          check_field("status", WORD_W'(out_item.status), WORD_W'(want_reply.status));
          check_field("entry_count", WORD_W'(out_item.entry_count),
                      WORD_W'(want_reply.entry_count));
          case (want_reply.status)
            lss_pkg::ST_OK:        tally_ok++;
            lss_pkg::ST_EMPTY:     tally_empty++;
            lss_pkg::ST_FULL:      tally_full++;
            lss_pkg::ST_NOT_FOUND: tally_missing++;
            default: ;
          endcase
          if (want_reply.position > deepest_match) deepest_match = want_reply.position;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, stack_replies.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus generation. The generator tracks the entry count on its own so it
  // can steer phases toward a full or an empty stack.
  logic signed [WORD_W-1:0] key_pool [16];
  int unsigned gen_count = 0;
  int unsigned random_done = 0;
  bit          burst = 1'b0;

  task automatic add_op(lss_pkg::mode_t mode, logic signed [WORD_W-1:0] value);
    pending_op_t p;
    p.op.mode = mode;
    p.op.value = value;
    p.gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    pending_ops.push_back(p);
    if (mode == lss_pkg::MODE_PUSH && gen_count < STACK_DEPTH) gen_count++;
    if (mode == lss_pkg::MODE_POP && gen_count > 0) gen_count--;
    if (mode != MODE_IGNORED) random_done++;
  endtask

  // Words from a small pool at the given percentage so that searches hit, else any word.
  function automatic logic signed [WORD_W-1:0] pick_word(int unsigned pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return key_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  initial begin
    int unsigned phase_kind;
    int unsigned phase_len;
    int unsigned roll;
    int unsigned i;

    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = '0;
    key_pool[3] = -32'sd1;
    for (i = 4; i < 16; i++) key_pool[i] = $urandom;

    // Directed opening: empty-stack cases, extreme words, duplicates, an
    // ignored mode with and without entries.
    add_op(lss_pkg::MODE_POP, 32'sd0);
    add_op(lss_pkg::MODE_SEARCH, 32'sd0);
    add_op(MODE_IGNORED, -32'sd1);
    add_op(lss_pkg::MODE_PUSH, 32'sh8000_0000);
    add_op(lss_pkg::MODE_PUSH, 32'sh7fff_ffff);
    add_op(lss_pkg::MODE_PUSH, 32'sd0);
    add_op(lss_pkg::MODE_PUSH, -32'sd1);
    add_op(lss_pkg::MODE_PUSH, 32'sh7fff_ffff);
    add_op(lss_pkg::MODE_SEARCH, 32'sh7fff_ffff);
    add_op(lss_pkg::MODE_SEARCH, 32'sh8000_0000);
    add_op(lss_pkg::MODE_SEARCH, 32'sd0);
    add_op(lss_pkg::MODE_SEARCH, 32'sd12345);
    add_op(MODE_IGNORED, 32'sh5555_5555);
    for (i = 0; i < 6; i++) add_op(lss_pkg::MODE_POP, 32'shaaaa_aaaa);
    add_op(lss_pkg::MODE_SEARCH, -32'sd1);
    random_done = 0;

    while (random_done < RANDOM_OPS) begin
      burst = ($urandom_range(0, 3) == 0);
      phase_kind = $urandom_range(0, 3);
      case (phase_kind)
        0: begin
          // Fill to the top with searches mixed in, then push against a full stack.
          while (gen_count < STACK_DEPTH) begin
            if ($urandom_range(0, 99) < 15) add_op(lss_pkg::MODE_SEARCH, pick_word(70));
            else add_op(lss_pkg::MODE_PUSH, pick_word(50));
          end
          phase_len = $urandom_range(1, 3);
          for (i = 0; i < phase_len; i++) add_op(lss_pkg::MODE_PUSH, pick_word(50));
          add_op(lss_pkg::MODE_SEARCH, pick_word(80));
        end
        1: begin
          // Drain to empty, then pop and search an empty stack.
          while (gen_count > 0) begin
            if ($urandom_range(0, 99) < 20) add_op(lss_pkg::MODE_SEARCH, pick_word(70));
            else add_op(lss_pkg::MODE_POP, $urandom);
          end
          add_op(lss_pkg::MODE_POP, $urandom);
          add_op(lss_pkg::MODE_SEARCH, pick_word(50));
        end
        2: begin
          phase_len = $urandom_range(20, 80);
          for (i = 0; i < phase_len; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) add_op(lss_pkg::MODE_SEARCH, pick_word(75));
            else if (roll < 80) add_op(lss_pkg::MODE_PUSH, pick_word(60));
            else add_op(lss_pkg::MODE_POP, $urandom);
          end
        end
        default: begin
          // Mixed noise, including the unused mode.
          phase_len = $urandom_range(20, 80);
          for (i = 0; i < phase_len; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) add_op(lss_pkg::MODE_PUSH, pick_word(40));
            else if (roll < 60) add_op(lss_pkg::MODE_POP, $urandom);
            else if (roll < 90) add_op(lss_pkg::MODE_SEARCH, pick_word(50));
            else add_op(MODE_IGNORED, $urandom);
          end
        end
      endcase
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge so the driver's and monitor's updates have settled.
    while (pending_ops.size() > 0 || in_valid || stack_replies.size() > 0)
      @(negedge clk);
    repeat (STACK_DEPTH + 8) @(posedge clk);

    $display("Checked %0d results: %0d ok, %0d empty, %0d full, %0d not found.",
             tally_ok + tally_empty + tally_full + tally_missing,
             tally_ok, tally_empty, tally_full, tally_missing);
    $display("Deepest search match at position %0d; %0d ignored-mode items; %0d mismatches.",
             deepest_match, ignored_ops, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
